// File: rtl/core/asfc_pkg.sv
// Shared types, character codes and helpers for the ASCII servo frame codec.
// No dependencies.
package asfc_pkg;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_PAYLOAD = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;
  localparam logic [1:0] CMD_RX      = 2'd3;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_RX_PAY  = 2'd1;
  localparam logic [1:0] KIND_RX_STAT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PARTNER  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;
  localparam logic [1:0] ST_LENGTH   = 2'd3;

  localparam logic [7:0] CH_SOH       = 8'h01;
  localparam logic [7:0] CH_STX       = 8'h02;
  localparam logic [7:0] CH_ETX       = 8'h03;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] HEX_ALPHA_OFS = CH_UPPER_A - 8'd10;

  localparam logic [5:0] RX_CNT_MAX = 6'd63;
  localparam logic [5:0] RX_IDX_SUM = 6'd3;
  localparam logic [5:0] RX_IDX_PAY = 6'd6;
  localparam logic [5:0] RX_IDX_CODE = 6'd2;

  localparam logic [2:0] HDR_LAST_STEP = 3'd6;
  localparam logic [2:0] FIN_LAST_STEP = 3'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    JOB_HDR  = 2'd0,
    JOB_BYTE = 2'd1,
    JOB_FIN  = 2'd2,
    JOB_RX   = 2'd3
  } job_op_t;

  // b[0..4]: header bytes (station char, code hi/lo, number hi/lo),
  // or the single byte / checksum in b[0].
  typedef struct packed {
    job_op_t         op;
    logic [4:0][7:0] b;
    logic            pay_v;
    logic            st_v;
    logic [1:0]      status;
    logic [7:0]      code;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] w;
    w = {4'd0, n};
    return (n >= 4'd10) ? (w + HEX_ALPHA_OFS) : (w + CH_ZERO);
  endfunction

endpackage

// File: rtl/core/asfc_front.sv
// Front end: accepts transactions, keeps tx/rx frame state and emits jobs.
// Depends on asfc_pkg.
module asfc_front import asfc_pkg::*; #(
  parameter int MAX_PAYLOAD = 10,
  parameter int MAX_REPLY   = 49
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_station,
  input  logic [7:0] in_code_hi,
  input  logic [7:0] in_code_lo,
  input  logic [7:0] in_number_hi,
  input  logic [7:0] in_number_lo,
  input  logic [7:0] in_value,
  input  logic       in_final_req,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [7:0]      tx_sum_r, tx_sum_nxt;
  logic [3:0]      tx_count_r, tx_count_nxt;
  logic [5:0]      rx_count_r, rx_count_nxt;
  logic [7:0]      rx_sum_r, rx_sum_nxt;
  logic [2:0][7:0] rx_delay_r, rx_delay_nxt;
  logic [7:0]      rx_code_r, rx_code_nxt;

  logic       acc;
  logic [7:0] stn_ch;
  logic [7:0] fin_sum;
  logic [7:0] rx_sum_upd;
  logic [7:0] rx_code_upd;
  logic       len_bad;
  logic       partner_bad;
  logic       cks_bad;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;
  assign stn_ch   = {3'd0, in_station} + CH_ZERO;
  assign fin_sum  = tx_sum_r + CH_ETX;

  assign rx_sum_upd  = (rx_count_r >= RX_IDX_SUM) ? (rx_sum_r + rx_delay_r[1]) : rx_sum_r;
  assign rx_code_upd = (rx_count_r == RX_IDX_CODE) ? in_value : rx_code_r;
  assign len_bad     = (rx_count_r < RX_IDX_SUM) || (rx_count_r >= 6'(MAX_REPLY)) ||
                       (rx_count_r == RX_CNT_MAX);
  assign partner_bad = (rx_code_upd != CH_UPPER_A) && (rx_code_upd != CH_LOWER_A);
  assign cks_bad     = (rx_delay_r[0] != hex_digit(rx_sum_upd[7:4])) ||
                       (in_value != hex_digit(rx_sum_upd[3:0]));

  always_comb begin
    tx_sum_nxt   = tx_sum_r;
    tx_count_nxt = tx_count_r;
    rx_count_nxt = rx_count_r;
    rx_sum_nxt   = rx_sum_r;
    rx_delay_nxt = rx_delay_r;
    rx_code_nxt  = rx_code_r;
    q_push       = 1'b0;
    q_job        = '0;
    if (acc) begin
      case (in_cmd)
        CMD_START: begin
          tx_sum_nxt   = stn_ch + in_code_hi + in_code_lo + CH_STX + in_number_hi + in_number_lo;
          tx_count_nxt = 4'd0;
          q_push       = 1'b1;
          q_job.op     = JOB_HDR;
          q_job.b[0]   = stn_ch;
          q_job.b[1]   = in_code_hi;
          q_job.b[2]   = in_code_lo;
          q_job.b[3]   = in_number_hi;
          q_job.b[4]   = in_number_lo;
        end
        CMD_PAYLOAD: begin
          if (tx_count_r < 4'(MAX_PAYLOAD)) begin
            tx_sum_nxt   = tx_sum_r + in_value;
            tx_count_nxt = tx_count_r + 4'd1;
            q_push       = 1'b1;
            q_job.op     = JOB_BYTE;
            q_job.b[0]   = in_value;
          end
        end
        CMD_FINISH: begin
          tx_sum_nxt   = 8'd0;
          tx_count_nxt = 4'd0;
          q_push       = 1'b1;
          q_job.op     = JOB_FIN;
          q_job.b[0]   = fin_sum;
        end
        CMD_RX: begin
          q_job.op     = JOB_RX;
          q_job.b[0]   = rx_delay_r[2];
          q_job.pay_v  = (rx_count_r >= RX_IDX_PAY);
          q_job.st_v   = in_final_req;
          q_job.code   = rx_code_upd;
          if (len_bad) begin
            q_job.status = ST_LENGTH;
          end else if (partner_bad) begin
            q_job.status = ST_PARTNER;
          end else if (cks_bad) begin
            q_job.status = ST_CHECKSUM;
          end else begin
            q_job.status = ST_OK;
          end
          q_push = q_job.pay_v || in_final_req;
          if (in_final_req) begin
            rx_count_nxt = 6'd0;
            rx_sum_nxt   = 8'd0;
            rx_delay_nxt = '0;
            rx_code_nxt  = 8'd0;
          end else begin
            rx_sum_nxt   = rx_sum_upd;
            rx_code_nxt  = rx_code_upd;
            rx_delay_nxt = {rx_delay_r[1], rx_delay_r[0], in_value};
            if (rx_count_r != RX_CNT_MAX) begin
              rx_count_nxt = rx_count_r + 6'd1;
            end
          end
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_sum_r   <= 8'd0;
      tx_count_r <= 4'd0;
      rx_count_r <= 6'd0;
      rx_sum_r   <= 8'd0;
      rx_delay_r <= '0;
      rx_code_r  <= 8'd0;
    end else begin
      tx_sum_r   <= tx_sum_nxt;
      tx_count_r <= tx_count_nxt;
      rx_count_r <= rx_count_nxt;
      rx_sum_r   <= rx_sum_nxt;
      rx_delay_r <= rx_delay_nxt;
      rx_code_r  <= rx_code_nxt;
    end
  end

endmodule

// File: rtl/core/asfc_queue.sv
// Short job queue between the front end and the back end.
// Depends on asfc_pkg.
module asfc_queue import asfc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + QPTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? (rd_ptr_r + QPTR_W'(1)) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && full |-> pop)
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_ptr_r + count_r[QPTR_W-1:0]) == wr_ptr_r)
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: rtl/core/asfc_back.sv
// Back end: expands queued jobs into result transactions, one per cycle unless out_ready stalls.
// Depends on asfc_pkg.
module asfc_back import asfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [1:0] out_status,
  output logic [7:0] out_partner_code,
  output logic       out_last
);

  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [1:0] status_r, status_nxt;
  logic [7:0] code_r, code_nxt;
  logic       last_r, last_nxt;
  logic [2:0] step_r;
  logic       last_step;
  logic       adv;

  assign adv   = !q_empty && (!valid_r || out_ready);
  assign q_pop = adv && last_step;

  always_comb begin
    byte_nxt   = 8'd0;
    kind_nxt   = KIND_TX;
    status_nxt = ST_OK;
    code_nxt   = 8'd0;
    last_nxt   = 1'b0;
    last_step  = 1'b1;
    case (head.op)
      JOB_HDR: begin
        last_step = (step_r == HDR_LAST_STEP);
        case (step_r)
          3'd0:    byte_nxt = CH_SOH;
          3'd1:    byte_nxt = head.b[0];
          3'd2:    byte_nxt = head.b[1];
          3'd3:    byte_nxt = head.b[2];
          3'd4:    byte_nxt = CH_STX;
          3'd5:    byte_nxt = head.b[3];
          3'd6:    byte_nxt = head.b[4];
          default: byte_nxt = CH_SOH;
        endcase
      end
      JOB_BYTE: begin
        byte_nxt = head.b[0];
      end
      JOB_FIN: begin
        last_step = (step_r == FIN_LAST_STEP);
        last_nxt  = last_step;
        case (step_r)
          3'd0:    byte_nxt = CH_ETX;
          3'd1:    byte_nxt = hex_digit(head.b[0][7:4]);
          default: byte_nxt = hex_digit(head.b[0][3:0]);
        endcase
      end
      JOB_RX: begin
        if (head.pay_v && (step_r == 3'd0)) begin
          byte_nxt  = head.b[0];
          kind_nxt  = KIND_RX_PAY;
          last_step = !head.st_v;
        end else begin
          kind_nxt   = KIND_RX_STAT;
          status_nxt = head.status;
          code_nxt   = head.code;
          last_nxt   = 1'b1;
        end
      end
      default: begin
        last_step = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 3'd0;
    end else if (adv) begin
      valid_r <= 1'b1;
      step_r  <= last_step ? 3'd0 : step_r + 3'd1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r   <= byte_nxt;
      kind_r   <= kind_nxt;
      status_r <= status_nxt;
      code_r   <= code_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_kind         = kind_r;
  assign out_status       = status_r;
  assign out_partner_code = code_r;
  assign out_last         = last_r;

endmodule

// File: rtl/core/ascii_servo_frame_codec.sv
// ASCII servo frame codec, top level: front end, job queue, back end.
// A transaction's results pass through the job queue and then the output register.
// Throughput: one input per cycle while the queue has room; the back end emits one result
// per cycle unless out_ready stalls; start 7 results, payload 1, finish 3, rx 0 to 2.
// Reset: synchronous active-low rst_n clears frame state, queue and output valid.
// Depends on asfc_pkg, asfc_front, asfc_queue, asfc_back.
module ascii_servo_frame_codec import asfc_pkg::*; #(
  parameter int MAX_PAYLOAD = 10,
  parameter int MAX_REPLY   = 49
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_station,
  input  logic [7:0] in_code_hi,
  input  logic [7:0] in_code_lo,
  input  logic [7:0] in_number_hi,
  input  logic [7:0] in_number_lo,
  input  logic [7:0] in_value,
  input  logic       in_final_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [1:0] out_status,
  output logic [7:0] out_partner_code,
  output logic       out_last
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_job;
  job_t q_head;

  asfc_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_REPLY   (MAX_REPLY)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_station   (in_station),
    .in_code_hi   (in_code_hi),
    .in_code_lo   (in_code_lo),
    .in_number_hi (in_number_hi),
    .in_number_lo (in_number_lo),
    .in_value     (in_value),
    .in_final_req (in_final_req),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  asfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  asfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_partner_code (out_partner_code),
    .out_last         (out_last)
  );

endmodule
